/* rtl/csam_pkg.sv */
// Package for the CHW scratchpad address map: shared types, widths, status codes,
// register indexes and the reciprocal table for the rows-per-word divide.
// No dependencies.
package csam_pkg;

   localparam int COORD_W  = 16;
   localparam int DSR_W    = 7;
   localparam int RECIP_W  = 17;
   localparam int RECIP_SH = 16;
   localparam int SUM_W    = 60;
   localparam int STRIDE_W = 40;
   localparam int NB_W     = 56;
   localparam int TH_W     = 29;
   localparam int LANE_W   = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BATCH     = 3'd1;
   localparam logic [2:0] ST_CHANNEL   = 3'd2;
   localparam logic [2:0] ST_ROW       = 3'd3;
   localparam logic [2:0] ST_COL       = 3'd4;
   localparam logic [2:0] ST_OVERFLOW  = 3'd5;
   localparam logic [2:0] ST_BOUNDS    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_BATCH_EXTENT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_EXTENT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_EXTENT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_EXTENT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCRATCH_BASE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WORDS_PER_CHAN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_PACKED    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WORDS_PER_ROW  = 3'd7;

   // floor(2^16 / d); zero is taken as one
   localparam logic [RECIP_W-1:0] RP_RECIP [32] = '{
      17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
      17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
      17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
      17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114
   };

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_adv_type;

endpackage

/* rtl/csam_recip_div.sv */
// Three-stage divide of a 16-bit value by a small divisor via a reciprocal multiply
// and one correction step. Depends on csam_pkg.
module csam_recip_div
   import csam_pkg::*;
(
   input  logic                 clock,
   input  stage_adv_type        adv,
   input  logic [COORD_W-1:0]   dividend,
   input  logic [DSR_W-1:0]     divisor,
   input  logic [RECIP_W-1:0]   recip,
   output logic [COORD_W-1:0]   quotient,
   output logic [DSR_W-1:0]     remainder
);

   logic [COORD_W-1:0] dvd1_ff;
   logic [DSR_W-1:0]   dsr1_ff, dsr2_ff;
   logic [31:0]        prod1_ff;
   logic [31:0]        prod_in;
   logic [COORD_W-1:0] qest2_ff, rest2_ff;
   logic [COORD_W-1:0] qest_in, rest_in, q3_ff, q_in;
   logic [DSR_W-1:0]   r3_ff, r_in;
   logic [COORD_W+DSR_W-1:0] qd;

   always_comb begin
      prod_in = 32'(dividend) * 32'(recip);
      qest_in = prod1_ff[31:RECIP_SH];
      qd      = (COORD_W+DSR_W)'(qest_in) * (COORD_W+DSR_W)'(dsr1_ff);
      rest_in = dvd1_ff - qd[COORD_W-1:0];
      if (rest2_ff >= COORD_W'(dsr2_ff)) begin
         q_in = qest2_ff + COORD_W'(1);
         r_in = DSR_W'(rest2_ff - COORD_W'(dsr2_ff));
      end else begin
         q_in = qest2_ff;
         r_in = rest2_ff[DSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         dvd1_ff  <= dividend;
         dsr1_ff  <= divisor;
         prod1_ff <= prod_in;
      end
      if (adv.s2) begin
         qest2_ff <= qest_in;
         rest2_ff <= rest_in;
         dsr2_ff  <= dsr1_ff;
      end
      if (adv.s3) begin
         q3_ff <= q_in;
         r3_ff <= r_in;
      end
   end

   assign quotient  = q3_ff;
   assign remainder = r3_ff;

endmodule

/* rtl/chw_scratchpad_address_map.sv */
// CHW scratchpad address map: turns a (batch, channel, row, column) coordinate into a
// word offset, scratchpad row and lane. Five-stage pipeline, one coordinate per cycle
// while the response side accepts; each stage moves on when the stage after it has
// room, so bubbles close up while the output register holds. The user must write
// configuration through the csr_ port only while no transfer is in flight; the block
// does not enforce it. Depends on csam_pkg and csam_recip_div.
module chw_scratchpad_address_map
   import csam_pkg::*;
#(
   parameter int BLOCK_SIZE   = 16,
   parameter int NUM_LANES    = 16,
   parameter int BANK_ENTRIES = 16384,
   parameter int OFFSET_WIDTH = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // batch_index, channel_index, row_index, col_index
   input  logic [63:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // word_offset[39:0], scratch_row[53:40], lane[57:54], status[60:58], zero fill
   output logic [63:0]          rsp_tdata,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [RECIP_W-1:0] BS_RECIP = RECIP_W'((1 << RECIP_SH) / BLOCK_SIZE);
   localparam logic [DSR_W-1:0]   BS_DSR   = DSR_W'(BLOCK_SIZE);

   logic [15:0] batch_extent_ff, channel_extent_ff, height_extent_ff, width_extent_ff;
   logic [13:0] scratch_base_ff;
   logic [23:0] words_per_channel_ff;
   logic [4:0]  rows_packed_ff;
   logic [12:0] words_per_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_extent_ff      <= 16'd1;
         channel_extent_ff    <= 16'd1;
         height_extent_ff     <= 16'd1;
         width_extent_ff      <= 16'd1;
         scratch_base_ff      <= 14'd0;
         words_per_channel_ff <= 24'd1;
         rows_packed_ff       <= 5'd1;
         words_per_row_ff     <= 13'd1;
      end else if (csr_wen) begin
         case (csr_index)
            REG_BATCH_EXTENT:   batch_extent_ff      <= csr_wdata[15:0];
            REG_CHANNEL_EXTENT: channel_extent_ff    <= csr_wdata[15:0];
            REG_HEIGHT_EXTENT:  height_extent_ff     <= csr_wdata[15:0];
            REG_WIDTH_EXTENT:   width_extent_ff      <= csr_wdata[15:0];
            REG_SCRATCH_BASE:   scratch_base_ff      <= csr_wdata[13:0];
            REG_WORDS_PER_CHAN: words_per_channel_ff <= csr_wdata[23:0];
            REG_ROWS_PACKED:    rows_packed_ff       <= csr_wdata[4:0];
            REG_WORDS_PER_ROW:  words_per_row_ff     <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   stage_adv_type adv;

   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign adv = '{s1: rdy1, s2: rdy2, s3: rdy3};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // stage 1: range checks, stride and per-item products, divider operands
   logic [COORD_W-1:0]  n_in, c_in, h_in, w_in;
   logic [2:0]          code_in;
   logic [STRIDE_W-1:0] stride_in, tc_in;
   logic [TH_W-1:0]     th_in;
   logic                narrow_in;
   logic [COORD_W-1:0]  dvd_in;
   logic [DSR_W-1:0]    dsr_in;
   logic [RECIP_W-1:0]  recip_in;

   always_comb begin
      n_in = req_tdata[15:0];
      c_in = req_tdata[31:16];
      h_in = req_tdata[47:32];
      w_in = req_tdata[63:48];
      if (n_in >= batch_extent_ff)        code_in = ST_BATCH;
      else if (c_in >= channel_extent_ff) code_in = ST_CHANNEL;
      else if (h_in >= height_extent_ff)  code_in = ST_ROW;
      else if (w_in >= width_extent_ff)   code_in = ST_COL;
      else                                code_in = ST_OK;
      stride_in = STRIDE_W'(channel_extent_ff) * STRIDE_W'(words_per_channel_ff);
      tc_in     = STRIDE_W'(c_in) * STRIDE_W'(words_per_channel_ff);
      th_in     = TH_W'(h_in) * TH_W'(words_per_row_ff);
      narrow_in = 32'(width_extent_ff) <= 32'(BLOCK_SIZE);
      if (narrow_in) begin
         dvd_in   = h_in;
         dsr_in   = (rows_packed_ff == 5'd0) ? DSR_W'(1) : DSR_W'(rows_packed_ff);
         recip_in = RP_RECIP[rows_packed_ff];
      end else begin
         dvd_in   = w_in;
         dsr_in   = BS_DSR;
         recip_in = BS_RECIP;
      end
   end

   logic [COORD_W-1:0]  n1_ff, w1_ff, w2_ff, w3_ff;
   logic [2:0]          code1_ff, code2_ff, code3_ff, code4_ff;
   logic [STRIDE_W-1:0] stride1_ff, tc1_ff, tc2_ff;
   logic [TH_W-1:0]     th1_ff, th2_ff, th3_ff;
   logic                narrow1_ff, narrow2_ff, narrow3_ff;
   logic                sovf2_ff, sovf3_ff, sovf4_ff;
   logic [NB_W-1:0]     nb_in, nb2_ff;
   logic                sovf_in;
   logic [SUM_W-1:0]    a_in, a3_ff, off_in, off4_ff, total;
   logic [LANE_W-1:0]   lane_in, lane4_ff;
   logic [COORD_W-1:0]  quot;
   logic [DSR_W-1:0]    rem;

   csam_recip_div u_div (
      .clock     (clock),
      .adv       (adv),
      .dividend  (dvd_in),
      .divisor   (dsr_in),
      .recip     (recip_in),
      .quotient  (quot),
      .remainder (rem)
   );

   always_comb begin
      nb_in   = NB_W'(n1_ff) * NB_W'(stride1_ff);
      sovf_in = (stride1_ff >> OFFSET_WIDTH) != '0;
      a_in    = SUM_W'(nb2_ff) + SUM_W'(tc2_ff);
      off_in  = a3_ff + (narrow3_ff ? '0 : SUM_W'(th3_ff)) + SUM_W'(quot);
      lane_in = narrow3_ff ? (LANE_W'(rem) * LANE_W'(width_extent_ff) + LANE_W'(w3_ff))
                           : LANE_W'(rem);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         n1_ff      <= n_in;
         w1_ff      <= w_in;
         code1_ff   <= code_in;
         stride1_ff <= stride_in;
         tc1_ff     <= tc_in;
         th1_ff     <= th_in;
         narrow1_ff <= narrow_in;
      end
      if (rdy2) begin
         nb2_ff     <= nb_in;
         sovf2_ff   <= sovf_in;
         tc2_ff     <= tc1_ff;
         th2_ff     <= th1_ff;
         w2_ff      <= w1_ff;
         code2_ff   <= code1_ff;
         narrow2_ff <= narrow1_ff;
      end
      if (rdy3) begin
         a3_ff      <= a_in;
         sovf3_ff   <= sovf2_ff;
         th3_ff     <= th2_ff;
         w3_ff      <= w2_ff;
         code3_ff   <= code2_ff;
         narrow3_ff <= narrow2_ff;
      end
      if (rdy4) begin
         off4_ff  <= off_in;
         lane4_ff <= lane_in;
         sovf4_ff <= sovf3_ff;
         code4_ff <= code3_ff;
      end
   end

   // stage 5: row sum, overflow and bounds, output register
   logic [39:0] offset_out_in, offset_out_ff;
   logic [13:0] row_out_in, row_out_ff;
   logic [3:0]  lane_out_in, lane_out_ff;
   logic [2:0]  status_in, status_ff;

   always_comb begin
      total = off4_ff + SUM_W'(scratch_base_ff);
      if (code4_ff != ST_OK)
         status_in = code4_ff;
      else if (sovf4_ff || ((total >> OFFSET_WIDTH) != '0))
         status_in = ST_OVERFLOW;
      else if (32'(lane4_ff) >= 32'(NUM_LANES) || total >= SUM_W'(BANK_ENTRIES))
         status_in = ST_BOUNDS;
      else
         status_in = ST_OK;
      if (status_in == ST_OK) begin
         offset_out_in = off4_ff[39:0];
         row_out_in    = total[13:0];
         lane_out_in   = lane4_ff[3:0];
      end else begin
         offset_out_in = '0;
         row_out_in    = '0;
         lane_out_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         offset_out_ff <= offset_out_in;
         row_out_ff    <= row_out_in;
         lane_out_ff   <= lane_out_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {3'b000, status_ff, lane_out_ff, row_out_ff, offset_out_ff};

endmodule
